// File: rtl/mbss_pkg.sv
package mbss_pkg;

  // Configuration register indexes, in register-map order.
  typedef enum logic [2:0] {
    REG_PAT_0_7   = 3'd0,
    REG_PAT_8_15  = 3'd1,
    REG_PAT_16_23 = 3'd2,
    REG_PAT_24_31 = 3'd3,
    REG_CARE_MASK = 3'd4,
    REG_PAT_LEN   = 3'd5,
    REG_BASE      = 3'd6
  } cfg_reg_t;

  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 64;
  localparam int ADDR_W       = 32;
  localparam int LEN_FIELD_W  = 6;
  localparam int PAT_STORE_B  = 32;   // pattern bytes held by the registers
  localparam int PAD_BYTES    = 64;   // upper bound of the window depth

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] address;
  } result_t;

endpackage

// File: rtl/masked_byte_signature_scan.sv
// Channel  | Handshake             | Payload                        | Direction
// ---------+-----------------------+--------------------------------+----------
// input    | in_valid / in_stall   | data_byte[7:0], last_byte      | in
// output   | out_valid / out_stall | found, match_address[31:0]     | out
// config   | cfg_valid / cfg_ready | cfg_index[2:0], cfg_data[63:0] | in
//
// The scanner accepts one byte item per clock cycle while in_stall is low. The masked
// compare of the whole window against the aligned pattern is combinational, and
// its result is registered into the output buffer. Reset (rst, synchronous,
// active high) restores the registers to their reset values and empties the
// window and the output buffer. The output side is a two-entry buffer;
// in_stall rises only when both entries are full, so a held result never
// blocks the next byte by itself.
module masked_byte_signature_scan #(
  parameter int MAX_PATTERN_BYTES = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  // Byte items of the scanned region.
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          data_byte,
  input  logic                                last_byte,
  // Result items.
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                found,
  output logic [mbss_pkg::ADDR_W-1:0]         match_address,
  // Register writes.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mbss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mbss_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int W     = MAX_PATTERN_BYTES;
  localparam int LEN_W = $clog2(W + 1);
  localparam int AW    = mbss_pkg::ADDR_W;

  // Raw configuration registers.
  logic [8*mbss_pkg::PAT_STORE_B-1:0] pattern, pattern_next;
  logic [mbss_pkg::PAT_STORE_B-1:0]   care, care_next;
  logic [mbss_pkg::LEN_FIELD_W-1:0]   plen, plen_next;
  logic [AW-1:0]                      base, base_next;

  // Pattern and care mask realigned to window positions (entry 0 is the
  // newest byte), kept in step with the raw registers so that the per-byte
  // compare needs no variable indexing.
  logic [8*W-1:0]   want_al, want_al_next;
  logic [W-1:0]     care_al, care_al_next;
  logic [LEN_W-1:0] eff, eff_next;
  logic [AW-1:0]    base_off, base_off_next;

  // Region state.
  logic [7:0]    window [W];
  logic [7:0]    window_next [W];
  logic [7:0]    win_shift [W];
  logic [AW-1:0] bytes_seen, bytes_seen_next;
  logic          matched, matched_next;

  // Output buffer: a main register and a skid entry.
  mbss_pkg::result_t out_res, out_res_next, skid_res, skid_res_next, res;
  logic              out_vld, out_vld_next, skid_vld, skid_vld_next;

  logic                        accept;
  logic                        take_out;
  logic                        hit;
  logic                        is_match;
  logic                        res_valid;
  logic [AW-1:0]               seen_inc;
  logic [8*mbss_pkg::PAD_BYTES-1:0] pat_pad;
  logic [mbss_pkg::PAD_BYTES-1:0]   care_pad;
  logic [8*W-1:0]              pat_rev;
  logic [W-1:0]                care_rev;
  logic [LEN_W-1:0]            shamt;
  logic [6:0]                  len7;

  assign cfg_ready     = 1'b1;
  assign in_stall      = skid_vld;
  assign out_valid     = out_vld;
  assign found         = out_res.found;
  assign match_address = out_res.address;

  assign accept   = in_valid && !in_stall;
  assign take_out = out_vld && !out_stall;

  // Configuration writes. The next values also feed the realignment below,
  // so the aligned copies are current in the cycle after any write.
  always_comb begin
    pattern_next = pattern;
    care_next    = care;
    plen_next    = plen;
    base_next    = base;
    if (rst) begin
      pattern_next = '0;
      care_next    = '0;
      plen_next    = mbss_pkg::LEN_FIELD_W'(1);
      base_next    = '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mbss_pkg::REG_PAT_0_7:   pattern_next[63:0]    = cfg_data;
        mbss_pkg::REG_PAT_8_15:  pattern_next[127:64]  = cfg_data;
        mbss_pkg::REG_PAT_16_23: pattern_next[191:128] = cfg_data;
        mbss_pkg::REG_PAT_24_31: pattern_next[255:192] = cfg_data;
        mbss_pkg::REG_CARE_MASK: care_next = cfg_data[31:0];
        mbss_pkg::REG_PAT_LEN:   plen_next = cfg_data[mbss_pkg::LEN_FIELD_W-1:0];
        mbss_pkg::REG_BASE:      base_next = cfg_data[AW-1:0];
        default: ;
      endcase
    end
  end

  // Realignment. Pattern byte i must sit at window entry len-1-i. Reversing
  // the byte order and shifting right by W-len does that, and it also clears
  // every position at or beyond len. Bytes past 31 are wildcards.
  always_comb begin
    pat_pad  = {256'b0, pattern_next};
    care_pad = {32'b0, care_next};
    for (int i = 0; i < W; i++) begin
      pat_rev[8*(W-1-i) +: 8] = pat_pad[8*i +: 8];
      care_rev[W-1-i]         = care_pad[i];
    end
    len7 = {1'b0, plen_next};
    if (len7 == 7'd0) begin
      eff_next = LEN_W'(1);
    end else if (len7 > 7'(W)) begin
      eff_next = LEN_W'(W);
    end else begin
      eff_next = LEN_W'(len7);
    end
    shamt         = LEN_W'(W) - eff_next;
    want_al_next  = pat_rev >> {shamt, 3'b000};
    care_al_next  = care_rev >> shamt;
    base_off_next = base_next - AW'(eff_next);
  end

  // Scan datapath.
  always_comb begin
    win_shift[0] = data_byte;
    for (int j = 1; j < W; j++) begin
      win_shift[j] = window[j-1];
    end
    hit = 1'b1;
    for (int j = 0; j < W; j++) begin
      if (care_al[j] && (win_shift[j] != want_al[8*j +: 8])) begin
        hit = 1'b0;
      end
    end
    seen_inc = (bytes_seen == '1) ? bytes_seen : bytes_seen + AW'(1);
    is_match = hit && (seen_inc >= AW'(eff));

    res_valid   = 1'b0;
    res.found   = is_match;
    res.address = is_match ? (base_off + seen_inc) : '0;

    window_next     = window;
    bytes_seen_next = bytes_seen;
    matched_next    = matched;

    if (rst) begin
      for (int j = 0; j < W; j++) begin
        window_next[j] = 8'h00;
      end
      bytes_seen_next = '0;
      matched_next    = 1'b0;
    end else if (accept) begin
      if (!matched) begin
        res_valid = is_match || last_byte;
      end
      if (last_byte) begin
        // End of region: start the next one from a clean window.
        for (int j = 0; j < W; j++) begin
          window_next[j] = 8'h00;
        end
        bytes_seen_next = '0;
        matched_next    = 1'b0;
      end else if (!matched) begin
        window_next     = win_shift;
        bytes_seen_next = seen_inc;
        matched_next    = is_match;
      end
    end
  end

  // Output buffer. The skid entry fills only when the main register is held
  // by the consumer; while it is full no new byte is accepted.
  always_comb begin
    out_res_next  = out_res;
    out_vld_next  = out_vld;
    skid_res_next = skid_res;
    skid_vld_next = skid_vld;
    if (rst) begin
      out_vld_next  = 1'b0;
      skid_vld_next = 1'b0;
    end else if (skid_vld) begin
      if (take_out) begin
        out_res_next  = skid_res;
        skid_vld_next = 1'b0;
      end
    end else if (!out_vld || take_out) begin
      out_vld_next = res_valid;
      if (res_valid) begin
        out_res_next = res;
      end
    end else if (res_valid) begin
      skid_res_next = res;
      skid_vld_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    pattern    <= pattern_next;
    care       <= care_next;
    plen       <= plen_next;
    base       <= base_next;
    want_al    <= want_al_next;
    care_al    <= care_al_next;
    eff        <= eff_next;
    base_off   <= base_off_next;
    window     <= window_next;
    bytes_seen <= bytes_seen_next;
    matched    <= matched_next;
    out_res    <= out_res_next;
    out_vld    <= out_vld_next;
    skid_res   <= skid_res_next;
    skid_vld   <= skid_vld_next;
  end

endmodule

// File: rtl/mbss_checker.sv
module mbss_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        found,
  input logic [mbss_pkg::ADDR_W-1:0] match_address
);

  // A held result keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(found) && $stable(match_address))
    else $error("result changed while stalled");

  // A not-found result always carries address zero.
  a_notfound_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> match_address == '0)
    else $error("not-found result with nonzero address");

  // A result appears only after a byte item was taken.
  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    out_valid && !$past(out_valid) |-> $past(in_valid && !in_stall))
    else $error("result without an input item");

  // Reset empties the output buffer.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("output buffer not empty after reset");

endmodule

bind masked_byte_signature_scan mbss_checker u_mbss_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .found         (found),
  .match_address (match_address)
);

// File: sim/masked_byte_signature_scan_tb.sv
`timescale 1ns / 100ps

module masked_byte_signature_scan_tb;

  // Clock period in ns, and the cycles that reset stays asserted.
  localparam int CLK_PERIOD    = 20;
  localparam int RESET_CYCLES  = 7;
  // The result of a byte is registered and may sit in the
  // two-entry output buffer. This many quiet cycles after the last
  // expected result are enough for the block to be truly idle.
  localparam int SETTLE_CYCLES = 6;
  // Length of the long receiver hold-off that fills the block up.
  localparam int HOLD_CYCLES   = 300;
  // Items in one random phase, and regions between two register setups.
  localparam int PHASE_ITEMS   = 170;
  localparam int SETUP_REGIONS = 6;

  // How a random region is built around the configured signature.
  typedef enum int {
    PLANT_NONE,  // noise only, a match can still happen by chance
    PLANT_FULL,  // the whole signature lies somewhere inside the region
    PLANT_CUT    // the head of the signature sits at the region end, cut short
  } plant_mode_t;

  logic                            clk           = 1'b0;
  logic                            rst           = 1'b1;
  logic                            in_valid      = 1'b0;
  logic                            in_stall;
  logic [7:0]                      data_byte     = '0;
  logic                            last_byte     = 1'b0;
  logic                            out_valid;
  logic                            out_stall     = 1'b0;
  logic                            found;
  logic [mbss_pkg::ADDR_W-1:0]     match_address;
  logic                            cfg_valid     = 1'b0;
  logic                            cfg_ready;
  logic [mbss_pkg::CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [mbss_pkg::CFG_DATA_W-1:0] cfg_data      = '0;

  masked_byte_signature_scan dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .last_byte     (last_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .found         (found),
    .match_address (match_address),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Shadow copy of the register file, updated at the edge where a write
  // is taken, so the prediction always sees what the block sees.
  logic [63:0] sig_words [4] = '{default: '0};
  logic [31:0] sig_care      = '0;
  logic [5:0]  sig_len       = 6'd1;
  logic [31:0] sig_base      = '0;

  // Predicted scanner state: the byte window (entry 0 is the newest),
  // the count of region bytes taken so far, and the matched flag.
  logic [7:0]  scan_window [32] = '{default: '0};
  logic [31:0] scan_seen        = '0;
  logic        scan_matched     = 1'b0;

  // Results worked out for accepted bytes, oldest first.
  mbss_pkg::result_t pending_scan_results [$];

  // Idling controls shared by the sender and the receiver.
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int hold_requests      = 0;
  int hold_served        = 0;
  int hold_left          = 0;

  // Run statistics.
  int items_sent         = 0;
  int regions_sent       = 0;
  int matches_predicted  = 0;
  int results_checked    = 0;
  int input_stall_cycles = 0;
  int mismatches         = 0;

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // A fixed ceiling on the run; a correct run ends long before it.
  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  // Pattern lengths of zero count as one; above the window depth they
  // saturate to the full 32 bytes.
  function automatic int effective_sig_len();
    if (sig_len == 6'd0) return 1;
    if (sig_len > 6'd32) return 32;
    return int'(sig_len);
  endfunction

  function automatic logic [7:0] sig_byte(input int idx);
    return sig_words[idx / 8][(idx % 8) * 8 +: 8];
  endfunction

  function automatic void clear_scan_region();
    scan_window  = '{default: '0};
    scan_seen    = '0;
    scan_matched = 1'b0;
  endfunction

  // Shifts one accepted byte into the predicted window and queues the result
  // it causes, if any. After a match the rest of the region is ignored until
  // its last byte, which only resets the region state.
  function automatic void predict_scan(input logic [7:0] value, input logic is_last);
    mbss_pkg::result_t res;
    int                len;
    int                i;
    logic              hit;
    if (is_last) regions_sent++;
    if (scan_matched) begin
      if (is_last) clear_scan_region();
      return;
    end
    for (i = 31; i > 0; i--) scan_window[i] = scan_window[i - 1];
    scan_window[0] = value;
    if (scan_seen != 32'hFFFF_FFFF) scan_seen++;
    len = effective_sig_len();
    // A match must lie wholly inside the region, so the bytes still at
    // their reset value never take part.
    hit = (scan_seen >= 32'(len));
    for (i = 0; i < len; i++) begin
      if (sig_care[i] && sig_byte(i) != scan_window[len - 1 - i]) hit = 1'b0;
    end
    if (hit) begin
      res.found   = 1'b1;
      res.address = sig_base + (scan_seen - 32'(len));
      pending_scan_results.insert(pending_scan_results.size(), res);
      matches_predicted++;
      if (is_last) clear_scan_region();
      else scan_matched = 1'b1;
    end else if (is_last) begin
      res.found   = 1'b0;
      res.address = '0;
      pending_scan_results.insert(pending_scan_results.size(), res);
      clear_scan_region();
    end
  endfunction

  // ---------------------------------------------------------------------
  // Receiver and result checking
  // ---------------------------------------------------------------------

  // Random stalls, plus a long hold-off when a test asks for one. The
  // hold-off is counted here so that the sender keeps offering items.
  always @(posedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // Every accepted result is held against the oldest prediction.
  always @(posedge clk) begin : result_check
    mbss_pkg::result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_scan_results.size() == 0) begin
        $display("%0t: result with nothing expected: expected none, actual found=%0b addr=%h",
                 $time, found, match_address);
        mismatches++;
      end else begin
        want = pending_scan_results.pop_front();
        results_checked++;
        if (found !== want.found) begin
          $display("%0t: found mismatch: expected %0b, actual %0b",
                   $time, want.found, found);
          mismatches++;
        end
        if (match_address !== want.address) begin
          $display("%0t: match_address mismatch: expected %h, actual %h",
                   $time, want.address, match_address);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sender and register access
  // ---------------------------------------------------------------------

  // Offers one byte item, with random idle cycles ahead of it, and waits
  // for the edge that takes it. Valid stays high on return so that back to
  // back items never see valid dropped and raised in the same step.
  task automatic send_byte(input logic [7:0] value, input logic is_last);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= value;
    last_byte <= is_last;
    do begin
      @(posedge clk);
      if (in_stall) input_stall_cycles++;
    end while (in_stall);
    predict_scan(value, is_last);
    items_sent++;
  endtask

  // Stops offering items and waits until every predicted result has been
  // taken, then lets the pipeline settle so a register write is safe.
  task automatic wait_scanner_idle();
    in_valid <= 1'b0;
    while (pending_scan_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input mbss_pkg::cfg_reg_t idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      mbss_pkg::REG_PAT_0_7:   sig_words[0] = value;
      mbss_pkg::REG_PAT_8_15:  sig_words[1] = value;
      mbss_pkg::REG_PAT_16_23: sig_words[2] = value;
      mbss_pkg::REG_PAT_24_31: sig_words[3] = value;
      mbss_pkg::REG_CARE_MASK: sig_care     = value[31:0];
      mbss_pkg::REG_PAT_LEN:   sig_len      = value[5:0];
      mbss_pkg::REG_BASE:      sig_base     = value[31:0];
      default: ;
    endcase
  endtask

  // Writes the whole register file once the block is idle. The upper bits
  // of the narrow registers carry whatever the caller passes, so the block
  // must drop them.
  task automatic program_scanner(input logic [63:0] w0, input logic [63:0] w1,
                                 input logic [63:0] w2, input logic [63:0] w3,
                                 input logic [63:0] care_data,
                                 input logic [63:0] len_data,
                                 input logic [63:0] base_data);
    wait_scanner_idle();
    write_reg(mbss_pkg::REG_PAT_0_7, w0);
    write_reg(mbss_pkg::REG_PAT_8_15, w1);
    write_reg(mbss_pkg::REG_PAT_16_23, w2);
    write_reg(mbss_pkg::REG_PAT_24_31, w3);
    write_reg(mbss_pkg::REG_CARE_MASK, care_data);
    write_reg(mbss_pkg::REG_PAT_LEN, len_data);
    write_reg(mbss_pkg::REG_BASE, base_data);
    cfg_valid <= 1'b0;
  endtask

  // Random register setup, weighted toward short signatures but reaching
  // the full window, a zero length and the oversized lengths as well.
  task automatic program_random_setup();
    logic [31:0] care;
    logic [31:0] base;
    logic [5:0]  plen;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 55) plen = 6'($urandom_range(1, 8));
    else if (pick < 75) plen = 6'($urandom_range(9, 32));
    else if (pick < 85) plen = 6'd32;
    else if (pick < 92) plen = 6'd0;
    else plen = 6'($urandom_range(33, 63));
    pick = $urandom_range(9);
    if (pick < 5) care = $urandom;
    else if (pick < 8) care = 32'hFFFF_FFFF;
    else if (pick < 9) care = 32'h0;
    else care = $urandom & $urandom;
    pick = $urandom_range(9);
    if (pick == 0) base = 32'hFFFF_FFFF - $urandom_range(40);
    else if (pick == 1) base = 32'h0;
    else base = $urandom;
    program_scanner({$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, care}, {$urandom, 26'($urandom), plen},
                    {$urandom, base});
  endtask

  // Half the noise bytes are drawn from the signature itself, which makes
  // near misses and overlapping partial matches common.
  function automatic logic [7:0] noise_byte();
    if ($urandom_range(1) == 0) return 8'($urandom);
    return sig_byte($urandom_range(effective_sig_len() - 1));
  endfunction

  // Builds one region of the given length around the current signature
  // and sends it, with the last-byte flag on its final item.
  task automatic send_region(input int region_len, input plant_mode_t mode);
    logic [7:0] region_bytes [$];
    int         len;
    int         start;
    int         cut;
    int         k;
    len = effective_sig_len();
    for (k = 0; k < region_len; k++) region_bytes.insert(region_bytes.size(), noise_byte());
    if (mode == PLANT_FULL && region_len >= len) begin
      // Wildcard positions keep their noise.
      start = $urandom_range(region_len - len);
      for (k = 0; k < len; k++) begin
        if (sig_care[k]) region_bytes[start + k] = sig_byte(k);
      end
    end else if (mode == PLANT_CUT) begin
      cut = (len - 1 < region_len) ? len - 1 : region_len;
      for (k = 0; k < cut; k++) begin
        if (sig_care[k]) region_bytes[region_len - cut + k] = sig_byte(k);
      end
    end
    for (k = 0; k < region_len; k++) send_byte(region_bytes[k], k == region_len - 1);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Hand-picked regions: the reset setup, a wildcard in the signature, a
  // region shorter than the signature, a match on the last byte, bytes
  // ignored after a match, an address that wraps, and a zero length.
  task automatic test_directed();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    // After reset the length is one and every byte is a wildcard, so the
    // very first byte matches at the base address.
    send_byte(8'hA5, 1'b1);
    // Signature DE AD ?? EF with a base that wraps past the top of memory.
    program_scanner(64'h0000_0000_EF55_ADDE, '0, '0, '0,
                    64'hDEAD_BEEF_0000_000B, 64'hFFFF_FFFF_FFFF_FFC4,
                    64'h1234_5678_FFFF_FFFF);
    // Match at offset one; the byte after it is ignored.
    send_byte(8'h00, 1'b0);
    send_byte(8'hDE, 1'b0);
    send_byte(8'hAD, 1'b0);
    send_byte(8'h77, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hFF, 1'b1);
    // The region ends before the signature can fit.
    send_byte(8'hDE, 1'b0);
    send_byte(8'hAD, 1'b1);
    // The match completes on the last byte of the region.
    send_byte(8'hDE, 1'b0);
    send_byte(8'hAD, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hEF, 1'b1);
    // A length of zero behaves as one; byte 0 of the signature is FF.
    program_scanner(64'h0000_0000_0000_00FF, '0, '0, '0,
                    64'h0000_0000_FFFF_FFFF, 64'h0, 64'h0000_0000_0000_1000);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
  endtask

  // Signatures that fill the whole window, including oversized lengths
  // that must saturate, and the all-zero signature against a window that
  // still holds its reset zeros.
  task automatic test_long_patterns();
    int k;
    sender_idle_pct    = 6;
    receiver_stall_pct = 6;
    program_scanner('1, '1, '1, '1, 64'hFFFF_FFFF_FFFF_FFFF,
                    64'h0000_0000_0000_003F, 64'h0000_0000_FFFF_FFF0);
    for (k = 0; k < 33; k++) send_byte(8'hFF, k == 32);
    send_region(40, PLANT_FULL);
    // Thirty-one zero bytes must not match a 32-byte zero signature.
    program_scanner('0, '0, '0, '0, 64'h0000_0000_FFFF_FFFF,
                    64'h0000_0000_0000_0020, 64'h0);
    for (k = 0; k < 31; k++) send_byte(8'h00, k == 30);
    for (k = 0; k < 32; k++) send_byte(8'h00, k == 31);
    program_scanner({$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom},
                    {32'h0, $urandom}, 64'h0000_0000_0000_0021, {32'h0, $urandom});
    send_region(45, PLANT_FULL);
    send_region(20, PLANT_CUT);
  endtask

  // Every byte is a one-byte region that matches, so each item makes a
  // result. The receiver holds off for a long stretch while the sender
  // keeps going, which fills the output buffer and stalls the input.
  task automatic test_backpressure();
    int k;
    program_scanner({$urandom, $urandom}, '0, '0, '0, 64'h0,
                    64'h0000_0000_0000_0001, {32'h0, $urandom});
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_requests++;
    for (k = 0; k < 40; k++) send_byte(8'($urandom), 1'b1);
  endtask

  // Mostly well-formed regions that carry the signature, with noise-only
  // regions and cut-off signatures mixed in, under new random registers
  // every few regions.
  task automatic test_random_phase(input int sender_pct, input int stall_pct);
    int          first_item;
    int          region_count;
    int          region_len;
    int          pick;
    plant_mode_t mode;
    sender_idle_pct    = sender_pct;
    receiver_stall_pct = stall_pct;
    first_item   = items_sent;
    region_count = 0;
    while (items_sent - first_item < PHASE_ITEMS) begin
      if (region_count % SETUP_REGIONS == 0) program_random_setup();
      if ($urandom_range(9) == 0) region_len = $urandom_range(1, 64);
      else region_len = $urandom_range(1, effective_sig_len() + 10);
      pick = $urandom_range(99);
      if (pick < 60) mode = PLANT_FULL;
      else if (pick < 75) mode = PLANT_CUT;
      else mode = PLANT_NONE;
      send_region(region_len, mode);
      region_count++;
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_long_patterns();
    test_backpressure();
    test_random_phase(0, 0);
    test_random_phase(68, 0);
    test_random_phase(0, 68);
    test_random_phase(6, 6);

    // Let the last results drain; a result still missing ends in the
    // timeout above.
    wait_scanner_idle();

    $display("Scanned %0d byte items in %0d regions; %0d results checked, %0d of them matches.",
             items_sent, regions_sent, results_checked, matches_predicted);
    $display("The input was stalled for %0d cycles while the receiver held off.",
             input_stall_cycles);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
